[hdl/swd_host_transaction_engine_top_defines.svh]
// ----------------------------------------------------------------------------
// SWD host transaction engine: assertion macros
// Shared check macros; they compile to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SWD_HOST_TRANSACTION_ENGINE_TOP_DEFINES_SVH
`define SWD_HOST_TRANSACTION_ENGINE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off while rst_n is low
`define SWDHTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swdhte: same-cycle check failed");
// next-cycle implication
`define SWDHTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swdhte: next-cycle check failed");
`else
`define SWDHTE_ASSERT_IMP(lbl, ante, cons)
`define SWDHTE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hdl/swdhte_pkg.sv]
// ----------------------------------------------------------------------------
// SWD host transaction engine package
// Command and phase codes, header constants, request and result records.
// ----------------------------------------------------------------------------
package swdhte_pkg;

  typedef enum logic [1:0] {
    CMD_READ       = 2'd0,
    CMD_WRITE      = 2'd1,
    CMD_LINE_RESET = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_t;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_HDR    = 11'b000_0000_0010,
    PH_TRN_A  = 11'b000_0000_0100,
    PH_ACK    = 11'b000_0000_1000,
    PH_TRN_W  = 11'b000_0001_0000,
    PH_WDATA  = 11'b000_0010_0000,
    PH_RDATA  = 11'b000_0100_0000,
    PH_RPAR   = 11'b000_1000_0000,
    PH_TRN_R  = 11'b001_0000_0000,
    PH_RST_HI = 11'b010_0000_0000,
    PH_RST_LO = 11'b100_0000_0000
  } phase_t;

  // request header: start, APnDP, RnW, A2, A3, parity, stop, park (LSB first)
  localparam logic [7:0] HDR_WRITE_BASE = 8'h81;
  localparam logic [7:0] HDR_READ_BASE  = 8'h85;
  localparam logic [7:0] HDR_APNDP      = 8'h02;
  localparam logic [7:0] HDR_A2         = 8'h08;
  localparam logic [7:0] HDR_A3         = 8'h10;
  localparam logic [7:0] HDR_PARITY     = 8'h20;

  localparam logic [5:0] HDR_BITS    = 6'd8;
  localparam logic [5:0] ACK_BITS    = 6'd3;
  localparam logic [5:0] WDATA_BITS  = 6'd33;
  localparam logic [5:0] RDATA_BITS  = 6'd32;
  localparam logic [5:0] RST_HI_CLKS = 6'd56;
  localparam logic [5:0] RST_LO_CLKS = 6'd8;

  localparam logic [2:0] ACK_OK = 3'b001;

  // classified request, as queued between front and engine
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  hdr;
    logic [32:0] wframe;    // data word plus parity in bit 32, zero for reads
    logic        swdio_in;
  } swd_req_t;

  typedef struct packed {
    logic        clock_pulse;
    logic        swdio_out;
    logic        swdio_drive;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  ack_code;
    logic [31:0] read_data;
    logic        parity_error;
    logic        request_rejected;
  } swd_res_t;

endpackage

[hdl/swd_host_transaction_engine_top.sv]
// ----------------------------------------------------------------------------
// SWD host transaction engine, top level
// Path: a request is registered in the front queue, passes the wire sequencer and
// is registered in the result queue; throughput is one request per cycle, set by the
// sequencer, which retires one request a cycle while the result queue has room.
// Reset: synchronous, active-low rst_n; both queues empty, sequencer idle.
// ----------------------------------------------------------------------------
module swd_host_transaction_engine_top
  import swdhte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_cmd,
  input  logic        in_ap_select,
  input  logic [1:0]  in_reg_addr_bits,
  input  logic [31:0] in_write_data,
  input  logic        in_swdio_in,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic        out_clock_pulse,
  output logic        out_swdio_out,
  output logic        out_swdio_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [2:0]  out_ack_code,
  output logic [31:0] out_read_data,
  output logic        out_parity_error,
  output logic        out_request_rejected
);

  // front -> engine
  logic     q_valid;
  logic     q_pop;
  swd_req_t q_data;
  // engine -> result queue
  logic     res_push;
  logic     res_full;
  swd_res_t res_data;
  swd_res_t head;

  // Front: precomputes the 8-bit request header (with its parity) and the
  // 33-bit write frame (data plus even parity) so the sequencer only shifts.
  swdhte_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_cmd           (in_cmd),
    .in_ap_select     (in_ap_select),
    .in_reg_addr_bits (in_reg_addr_bits),
    .in_write_data    (in_write_data),
    .in_swdio_in      (in_swdio_in),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_data           (q_data)
  );

  // Sequencer: every request yields exactly one result. Start requests latch
  // a read, write or line reset (or are rejected while busy); tick requests
  // advance one wire clock through header, turnaround, ack, data or line-reset phases.
  swdhte_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  // Result queue decouples the consumer; a stalled pop backs up into the
  // sequencer, and from there into the front queue and full.
  swdhte_res_q u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign out_clock_pulse      = head.clock_pulse;
  assign out_swdio_out        = head.swdio_out;
  assign out_swdio_drive      = head.swdio_drive;
  assign out_busy_res         = head.busy_res;
  assign out_done_res         = head.done_res;
  assign out_ack_code         = head.ack_code;
  assign out_read_data        = head.read_data;
  assign out_parity_error     = head.parity_error;
  assign out_request_rejected = head.request_rejected;

endmodule

[hdl/swdhte_front.sv]
// ----------------------------------------------------------------------------
// SWD front end
// Takes requests, builds the header and write frame, queues them (2 deep).
// ----------------------------------------------------------------------------
module swdhte_front
  import swdhte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_cmd,
  input  logic        in_ap_select,
  input  logic [1:0]  in_reg_addr_bits,
  input  logic [31:0] in_write_data,
  input  logic        in_swdio_in,
  output logic        q_valid,
  input  logic        q_pop,
  output swd_req_t    q_data
);

  swd_req_t   ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en;
  swd_req_t   req;
  logic       rd;
  logic       hpar;

  always_comb begin
    rd         = (cmd_t'(in_cmd) == CMD_READ);
    hpar       = rd ^ in_ap_select ^ in_reg_addr_bits[0] ^ in_reg_addr_bits[1];
    req.cmd    = cmd_t'(in_cmd);
    req.hdr    = (rd ? HDR_READ_BASE : HDR_WRITE_BASE)
               | (in_ap_select        ? HDR_APNDP  : 8'h00)
               | (in_reg_addr_bits[0] ? HDR_A2     : 8'h00)
               | (in_reg_addr_bits[1] ? HDR_A3     : 8'h00)
               | (hpar                ? HDR_PARITY : 8'h00);
    req.wframe = rd ? 33'd0 : {^in_write_data, in_write_data};
    req.swdio_in = in_swdio_in;
  end

  assign full    = (cnt_r == 2'd2);
  assign wr_en   = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ wr_en;
    rptr_nxt = rptr_r ^ q_pop;
    cnt_nxt  = cnt_r + {1'b0, wr_en} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wptr_r] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[hdl/swdhte_engine.sv]
// ----------------------------------------------------------------------------
// SWD wire sequencer
// Header, ack, data, line-reset phases; one request per cycle if not stalled.
// ----------------------------------------------------------------------------
`include "swd_host_transaction_engine_top_defines.svh"

module swdhte_engine
  import swdhte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_pop,
  input  swd_req_t q_data,
  input  logic     res_full,
  output logic     res_push,
  output swd_res_t res_data
);

  phase_t      phase_r, phase_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] tx_r, tx_nxt;
  logic [31:0] rx_r, rx_nxt;
  logic        par_r, par_nxt;
  logic [2:0]  ack_r, ack_nxt;
  logic        is_read_r, is_read_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic        fire;
  logic [5:0]  cnt_inc;
  logic [2:0]  ack_set;
  logic        din;

  assign fire     = q_valid && !res_full;
  assign q_pop    = fire;
  assign res_push = fire;
  assign cnt_inc  = cnt_r + 6'd1;
  assign din      = q_data.swdio_in;
  assign ack_set  = ack_r | (3'(din) << cnt_r[1:0]);

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    tx_nxt      = tx_r;
    rx_nxt      = rx_r;
    par_nxt     = par_r;
    ack_nxt     = ack_r;
    is_read_nxt = is_read_r;
    hdr_nxt     = hdr_r;
    res_data    = '0;

    if (fire) begin
      if (q_data.cmd != CMD_TICK) begin
        if (phase_r != PH_IDLE) begin
          res_data.request_rejected = 1'b1;
        end else begin
          ack_nxt = 3'd0;
          cnt_nxt = 6'd0;
          if (q_data.cmd == CMD_LINE_RESET) begin
            is_read_nxt = 1'b0;
            phase_nxt   = PH_RST_HI;
          end else begin
            hdr_nxt     = q_data.hdr;
            tx_nxt      = q_data.wframe;
            rx_nxt      = 32'd0;
            par_nxt     = 1'b0;
            is_read_nxt = (q_data.cmd == CMD_READ);
            phase_nxt   = PH_HDR;
          end
        end
      end else if (phase_r != PH_IDLE) begin
        res_data.clock_pulse = 1'b1;
        case (phase_r)
          PH_HDR: begin
            res_data.swdio_drive = 1'b1;
            res_data.swdio_out   = hdr_r[0];
            hdr_nxt              = {1'b0, hdr_r[7:1]};
            cnt_nxt              = cnt_inc;
            if (cnt_inc >= HDR_BITS) begin
              cnt_nxt   = 6'd0;
              phase_nxt = PH_TRN_A;
            end
          end
          PH_TRN_A: begin
            ack_nxt   = 3'd0;
            cnt_nxt   = 6'd0;
            phase_nxt = PH_ACK;
          end
          PH_ACK: begin
            ack_nxt = ack_set;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= ACK_BITS) begin
              cnt_nxt = 6'd0;
              if (ack_set == ACK_OK) begin
                phase_nxt = is_read_r ? PH_RDATA : PH_TRN_W;
              end else begin
                phase_nxt         = PH_IDLE;
                res_data.done_res = 1'b1;
              end
            end
          end
          PH_TRN_W: begin
            cnt_nxt   = 6'd0;
            phase_nxt = PH_WDATA;
          end
          PH_WDATA: begin
            res_data.swdio_drive = 1'b1;
            res_data.swdio_out   = tx_r[0];
            tx_nxt               = {1'b0, tx_r[32:1]};
            cnt_nxt              = cnt_inc;
            if (cnt_inc >= WDATA_BITS) begin
              cnt_nxt           = 6'd0;
              phase_nxt         = PH_IDLE;
              res_data.done_res = 1'b1;
            end
          end
          PH_RDATA: begin
            rx_nxt  = {din, rx_r[31:1]};
            par_nxt = par_r ^ din;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= RDATA_BITS) begin
              cnt_nxt   = 6'd0;
              phase_nxt = PH_RPAR;
            end
          end
          PH_RPAR: begin
            par_nxt   = par_r ^ din;
            phase_nxt = PH_TRN_R;
          end
          PH_TRN_R: begin
            res_data.read_data    = rx_r;
            res_data.parity_error = par_r;
            res_data.done_res     = 1'b1;
            phase_nxt             = PH_IDLE;
          end
          PH_RST_HI: begin
            res_data.swdio_drive = 1'b1;
            res_data.swdio_out   = 1'b1;
            cnt_nxt              = cnt_inc;
            if (cnt_inc >= RST_HI_CLKS) begin
              cnt_nxt   = 6'd0;
              phase_nxt = PH_RST_LO;
            end
          end
          PH_RST_LO: begin
            res_data.swdio_drive = 1'b1;
            cnt_nxt              = cnt_inc;
            if (cnt_inc >= RST_LO_CLKS) begin
              cnt_nxt           = 6'd0;
              phase_nxt         = PH_IDLE;
              res_data.done_res = 1'b1;
            end
          end
          default: begin
            res_data.clock_pulse = 1'b0;
            cnt_nxt              = 6'd0;
            phase_nxt            = PH_IDLE;
          end
        endcase
      end
      res_data.busy_res = (phase_nxt != PH_IDLE);
      res_data.ack_code = ack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= 6'd0;
      tx_r      <= 33'd0;
      rx_r      <= 32'd0;
      par_r     <= 1'b0;
      ack_r     <= 3'd0;
      is_read_r <= 1'b0;
      hdr_r     <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      tx_r      <= tx_nxt;
      rx_r      <= rx_nxt;
      par_r     <= par_nxt;
      ack_r     <= ack_nxt;
      is_read_r <= is_read_nxt;
      hdr_r     <= hdr_nxt;
    end
  end

  `SWDHTE_ASSERT_IMP(a_drive_needs_clk, res_push && res_data.swdio_drive, res_data.clock_pulse)
  `SWDHTE_ASSERT_IMP(a_done_goes_idle, res_push && res_data.done_res, phase_nxt == PH_IDLE)
  `SWDHTE_ASSERT_IMP(a_reject_holds, res_push && res_data.request_rejected, !res_data.clock_pulse && phase_nxt == phase_r)
  `SWDHTE_ASSERT_NXT(a_stall_holds_count, !fire && phase_r == PH_HDR, phase_r == PH_HDR && $stable(cnt_r))
  `SWDHTE_ASSERT_IMP(a_rdata_only_done, res_push && res_data.read_data != 32'd0, res_data.done_res)

endmodule

[hdl/swdhte_res_q.sv]
// ----------------------------------------------------------------------------
// SWD result queue
// Two-entry queue of results toward the consumer; full feeds back to engine.
// ----------------------------------------------------------------------------
module swdhte_res_q
  import swdhte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_push,
  input  swd_res_t res_data,
  output logic     res_full,
  output logic     empty,
  input  logic     pop,
  output swd_res_t head
);

  swd_res_t   ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_en;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign rd_en    = pop && !empty;
  assign head     = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ res_push;
    rptr_nxt = rptr_r ^ rd_en;
    cnt_nxt  = cnt_r + {1'b0, res_push} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      ent_r[wptr_r] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[tb/sv/swd_wire_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD wire-level checker
// Tracks the host engine's wire sequence per accepted request, queues the
// result each request should produce and compares what comes out.
// ----------------------------------------------------------------------------
package swd_wire_check_pkg;
  import swdhte_pkg::*;

  // ack patterns driven by the emulated target
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;
  localparam logic [2:0] ACK_NONE  = 3'b000;
  localparam logic [2:0] ACK_ALL   = 3'b111;

  class swd_wire_checker;
    phase_t      ph;
    logic [5:0]  bitcnt;
    logic [7:0]  hdr_bits;
    logic [32:0] tx_frame;
    logic [31:0] rx_word;
    logic        rx_par;
    logic [2:0]  ack_bits;
    logic        is_read;
    swd_res_t    results_due[$];
    int          errors;

    function new();
      ph       = PH_IDLE;
      bitcnt   = '0;
      hdr_bits = '0;
      tx_frame = '0;
      rx_word  = '0;
      rx_par   = 1'b0;
      ack_bits = '0;
      is_read  = 1'b0;
      errors   = 0;
    endfunction

    function bit idle();
      return ph == PH_IDLE;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // advance the wire sequence by one accepted request
    function void take_request(cmd_t cmd, logic ap, logic [1:0] addr, logic [31:0] wdata,
                               logic din);
      swd_res_t r;
      r = '0;
      if (cmd != CMD_TICK) begin
        if (ph != PH_IDLE) begin
          r.request_rejected = 1'b1;
        end else begin
          ack_bits = '0;
          bitcnt   = '0;
          if (cmd == CMD_LINE_RESET) begin
            is_read = 1'b0;
            ph      = PH_RST_HI;
          end else begin
            is_read  = (cmd == CMD_READ);
            // park, stop, parity, A3, A2, RnW, APnDP, start
            hdr_bits = {1'b1, 1'b0, ap ^ is_read ^ addr[0] ^ addr[1], addr[1], addr[0],
                        is_read, ap, 1'b1};
            tx_frame = is_read ? '0 : {^wdata, wdata};
            rx_word  = '0;
            rx_par   = 1'b0;
            ph       = PH_HDR;
          end
        end
      end else if (ph != PH_IDLE) begin
        r.clock_pulse = 1'b1;
        case (ph)
          PH_HDR: begin
            r.swdio_drive = 1'b1;
            r.swdio_out   = hdr_bits[0];
            hdr_bits      = hdr_bits >> 1;
            bitcnt        = bitcnt + 6'd1;
            if (bitcnt >= HDR_BITS) begin
              bitcnt = '0;
              ph     = PH_TRN_A;
            end
          end
          PH_TRN_A: begin
            ack_bits = '0;
            bitcnt   = '0;
            ph       = PH_ACK;
          end
          PH_ACK: begin
            ack_bits[bitcnt[1:0]] = ack_bits[bitcnt[1:0]] | din;
            bitcnt = bitcnt + 6'd1;
            if (bitcnt >= ACK_BITS) begin
              bitcnt = '0;
              if (ack_bits == ACK_OK) begin
                ph = is_read ? PH_RDATA : PH_TRN_W;
              end else begin
                ph         = PH_IDLE;
                r.done_res = 1'b1;
              end
            end
          end
          PH_TRN_W: begin
            bitcnt = '0;
            ph     = PH_WDATA;
          end
          PH_WDATA: begin
            r.swdio_drive = 1'b1;
            r.swdio_out   = tx_frame[0];
            tx_frame      = tx_frame >> 1;
            bitcnt        = bitcnt + 6'd1;
            if (bitcnt >= WDATA_BITS) begin
              bitcnt     = '0;
              ph         = PH_IDLE;
              r.done_res = 1'b1;
            end
          end
          PH_RDATA: begin
            rx_word = {din, rx_word[31:1]};
            rx_par  = rx_par ^ din;
            bitcnt  = bitcnt + 6'd1;
            if (bitcnt >= RDATA_BITS) begin
              bitcnt = '0;
              ph     = PH_RPAR;
            end
          end
          PH_RPAR: begin
            rx_par = rx_par ^ din;
            ph     = PH_TRN_R;
          end
          PH_TRN_R: begin
            r.read_data    = rx_word;
            r.parity_error = rx_par;
            ph             = PH_IDLE;
            r.done_res     = 1'b1;
          end
          PH_RST_HI: begin
            r.swdio_drive = 1'b1;
            r.swdio_out   = 1'b1;
            bitcnt        = bitcnt + 6'd1;
            if (bitcnt >= RST_HI_CLKS) begin
              bitcnt = '0;
              ph     = PH_RST_LO;
            end
          end
          PH_RST_LO: begin
            r.swdio_drive = 1'b1;
            bitcnt        = bitcnt + 6'd1;
            if (bitcnt >= RST_LO_CLKS) begin
              bitcnt     = '0;
              ph         = PH_IDLE;
              r.done_res = 1'b1;
            end
          end
          default: begin
            r.clock_pulse = 1'b0;
            bitcnt        = '0;
            ph            = PH_IDLE;
          end
        endcase
      end
      r.busy_res = (ph != PH_IDLE);
      r.ack_code = ack_bits;
      results_due.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(swd_res_t got);
      swd_res_t want;
      if (results_due.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      want = results_due.pop_front();
      cmp("clock_pulse", 32'(want.clock_pulse), 32'(got.clock_pulse));
      cmp("swdio_out", 32'(want.swdio_out), 32'(got.swdio_out));
      cmp("swdio_drive", 32'(want.swdio_drive), 32'(got.swdio_drive));
      cmp("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      cmp("done_res", 32'(want.done_res), 32'(got.done_res));
      cmp("ack_code", 32'(want.ack_code), 32'(got.ack_code));
      cmp("read_data", want.read_data, got.read_data);
      cmp("parity_error", 32'(want.parity_error), 32'(got.parity_error));
      cmp("request_rejected", 32'(want.request_rejected), 32'(got.request_rejected));
    endfunction
  endclass

endpackage

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD host transaction engine testbench
// Drives read, write and line reset sequences one wire tick per request,
// answering as a target would (ack, read data, parity), mixes in rejected
// starts and idle ticks, and checks every result against a wire-level model.
// ----------------------------------------------------------------------------
module tb_top;
  import swdhte_pkg::*;
  import swd_wire_check_pkg::*;

  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake on either side
  localparam int TARGET_ITEMS = 1300;
  localparam int TAIL_ITEMS   = 1100;  // past this, both sides run without idling
  localparam int DRAIN_AT     = 600;   // sender holds off here until all results land

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_cmd;
  logic        in_ap_select;
  logic [1:0]  in_reg_addr_bits;
  logic [31:0] in_write_data;
  logic        in_swdio_in;
  logic        empty;
  logic        pop;
  logic        out_clock_pulse;
  logic        out_swdio_out;
  logic        out_swdio_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic [2:0]  out_ack_code;
  logic [31:0] out_read_data;
  logic        out_parity_error;
  logic        out_request_rejected;

  swd_wire_checker sb;
  bit quiet_tail = 1'b0;
  int useful_items = 0;
  int quiet_cycles = 0;

  swd_host_transaction_engine_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_cmd               (in_cmd),
    .in_ap_select         (in_ap_select),
    .in_reg_addr_bits     (in_reg_addr_bits),
    .in_write_data        (in_write_data),
    .in_swdio_in          (in_swdio_in),
    .empty                (empty),
    .pop                  (pop),
    .out_clock_pulse      (out_clock_pulse),
    .out_swdio_out        (out_swdio_out),
    .out_swdio_drive      (out_swdio_drive),
    .out_busy_res         (out_busy_res),
    .out_done_res         (out_done_res),
    .out_ack_code         (out_ack_code),
    .out_read_data        (out_read_data),
    .out_parity_error     (out_parity_error),
    .out_request_rejected (out_request_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both handshakes at the rising edge. The request is noted before
  // the result is checked, so the model is always current.
  always @(posedge clk) begin
    if (push && !full) begin
      sb.take_request(cmd_t'(in_cmd), in_ap_select, in_reg_addr_bits, in_write_data,
                      in_swdio_in);
    end
    if (pop && !empty) begin
      sb.check_result({out_clock_pulse, out_swdio_out, out_swdio_drive, out_busy_res,
                       out_done_res, out_ack_code, out_read_data, out_parity_error,
                       out_request_rejected});
    end
    // watchdog: a long run with nothing moving means the block is hung
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: pop held high, with random stall bursts until the tail.
  initial begin
    int stall;
    stall = 0;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall = int'($urandom_range(1, 12));
      end
      pop <= (stall == 0);
    end
  end

  // One request, driven at a falling edge; returns at the falling edge after
  // it was taken. An idle burst may come first.
  task automatic send(cmd_t cmd, logic ap, logic [1:0] addr, logic [31:0] wdata,
                      logic din);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    push             <= 1'b1;
    in_cmd           <= cmd;
    in_ap_select     <= ap;
    in_reg_addr_bits <= addr;
    in_write_data    <= wdata;
    in_swdio_in      <= din;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Idle tick or a start that lands while busy: the sequence is left alone, and a start is flagged as rejected.
  task automatic send_noise(bit start);
    send(start ? cmd_t'($urandom_range(0, 2)) : CMD_TICK, 1'($urandom_range(0, 1)),
         2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Start a sequence, then tick until the model says the engine is idle. The
  // data line plays the target: ack on ticks 9..11 after the start, read data
  // on 12..43 and its parity on 44; everything else is random.
  task automatic run_access(cmd_t cmd, logic ap, logic [1:0] addr, logic [31:0] wdata,
                            logic [2:0] ack, logic [31:0] rdata, logic bad_par,
                            int reject_at);
    int  k;
    logic din;
    send(cmd, ap, addr, wdata, 1'($urandom_range(0, 1)));
    useful_items++;
    k = 0;
    while (!sb.idle()) begin
      din = 1'($urandom_range(0, 1));
      if (cmd != CMD_LINE_RESET) begin
        if (k >= 9 && k <= 11) din = ack[k - 9];
        else if (k >= 12 && k <= 43) din = rdata[k - 12];
        else if (k == 44) din = (^rdata) ^ bad_par;
      end
      if (k == reject_at) send_noise(1'b1);
      send(CMD_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom, din);
      useful_items++;
      k++;
    end
  endtask

  initial begin
    cmd_t        cmd;
    logic [2:0]  ack;
    logic [31:0] rdata;
    int          pick;
    bit          drained;

    sb               = new();
    drained          = 1'b0;
    rst_n            = 1'b0;
    push             = 1'b0;
    in_cmd           = CMD_TICK;
    in_ap_select     = 1'b0;
    in_reg_addr_bits = 2'd0;
    in_write_data    = '0;
    in_swdio_in      = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: tick while idle, AP write of all ones ending in FAULT with a
    // start rejected in the header, DP read with an all-ones (invalid) ack
    send(CMD_TICK, 1'b0, 2'd0, '0, 1'b0);
    run_access(CMD_WRITE, 1'b1, 2'd3, 32'hFFFF_FFFF, ACK_FAULT, '0, 1'b0, 0);
    run_access(CMD_READ, 1'b0, 2'd0, '0, ACK_ALL, '0, 1'b0, 5);

    while (useful_items < TARGET_ITEMS) begin
      if (useful_items >= TAIL_ITEMS) quiet_tail = 1'b1;

      // hold off once until every result has been popped
      if (!drained && useful_items >= DRAIN_AT) begin
        drained = 1'b1;
        push <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end

      pick = int'($urandom_range(0, 99));
      if (pick < 8) cmd = CMD_LINE_RESET;
      else if (pick < 54) cmd = CMD_READ;
      else cmd = CMD_WRITE;

      case ($urandom_range(0, 11))
        0: ack = ACK_WAIT;
        1: ack = ACK_FAULT;
        2: ack = ACK_NONE;
        3: ack = ACK_ALL;
        4: ack = 3'($urandom_range(0, 7));
        default: ack = ACK_OK;
      endcase

      case ($urandom_range(0, 9))
        0: rdata = '0;
        1: rdata = '1;
        default: rdata = $urandom;
      endcase

      run_access(cmd, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 ($urandom_range(0, 9) == 0) ? '0 : $urandom, ack, rdata,
                 $urandom_range(0, 5) == 0,
                 ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 40)) : -1);

      // ticks while idle between sequences
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise(1'b0);
      end
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // a little extra time to catch any stray result
    repeat (8) @(negedge clk);

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/swdhte_pkg.sv
hdl/swdhte_front.sv
hdl/swdhte_engine.sv
hdl/swdhte_res_q.sv
hdl/swd_host_transaction_engine_top.sv
tb/sv/swd_wire_check_pkg.sv
tb/sv/tb_top.sv
